/* rtl/core/ltws_pkg.sv */
package ltws_pkg;

	// Table geometry
	localparam int THREAD_COUNT = 8;
	localparam int TICKET_BITS  = 13;

	// Cell id width: wide enough for every cell and for the 3-bit thread field
	localparam int ID_W  = (THREAD_COUNT > 8) ? $clog2(THREAD_COUNT) : 3;
	// Running ticket sum never overflows
	localparam int SUM_W = TICKET_BITS + $clog2(THREAD_COUNT);
	// Common width for comparing the sum against 16-bit values
	localparam int CMP_W = (SUM_W > 16) ? SUM_W : 16;

	// Operation codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DRAW   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	typedef logic [TICKET_BITS-1:0] ticket_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [ID_W-1:0]        cell_id_t;

	// Command word
	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  thread_index;
		logic [12:0] ticket_count;
		logic [15:0] ticket_number;
	} cmd_word_t;

	// Result word
	typedef struct packed {
		logic [2:0]  winner_index;
		logic        winner_found;
		logic        winner_ran_before;
		logic [15:0] ticket_total;
	} res_word_t;

	// Token that walks down the row of cells
	typedef struct packed {
		logic        valid;
		cmd_word_t   cmd;
		sum_t        acc;
		logic        found;
		logic [2:0]  win;
		logic        ran;
	} token_t;

	// Keep only the low TICKET_BITS of a loaded count
	function automatic ticket_t ticket_of(input logic [12:0] count);
		return ticket_t'(count);
	endfunction

endpackage

/* rtl/core/ltws_cell.sv */
module ltws_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ltws_pkg::cell_id_t cell_id,
	input  ltws_pkg::token_t   tok_in,
	output ltws_pkg::token_t   tok_out
);
	import ltws_pkg::*;

	ticket_t tickets_q;
	logic    mark_q;
	token_t  tok_q;

	logic    addr_hit;
	logic    load_hit;
	logic    fin_hit;
	logic    draw_hit;
	ticket_t tickets_after;
	sum_t    acc_next;
	token_t  tok_next;

	// Address match, thread field zero-extended to the cell id width
	assign addr_hit = (cell_id == ID_W'(tok_in.cmd.thread_index));
	assign load_hit = tok_in.valid && (tok_in.cmd.opcode == OP_LOAD) && addr_hit;
	assign fin_hit  = tok_in.valid && (tok_in.cmd.opcode == OP_FINISH) && addr_hit;

	// Ticket count after this word; draws leave it alone
	always_comb begin
		if (load_hit) begin
			tickets_after = ticket_of(tok_in.cmd.ticket_count);
		end else if (fin_hit) begin
			tickets_after = '0;
		end else begin
			tickets_after = tickets_q;
		end
	end

	// Running sum doubles as the draw's prefix sum
	assign acc_next = tok_in.acc + SUM_W'(tickets_after);

	assign draw_hit = tok_in.valid && (tok_in.cmd.opcode == OP_DRAW) && !tok_in.found
		&& (tok_in.cmd.ticket_number != '0) && (tickets_q != '0)
		&& (CMP_W'(acc_next) >= CMP_W'(tok_in.cmd.ticket_number));

	// Token to the next cell
	always_comb begin
		tok_next     = tok_in;
		tok_next.acc = acc_next;
		if (draw_hit) begin
			tok_next.found = 1'b1;
			tok_next.win   = cell_id[2:0];
			tok_next.ran   = mark_q;
		end
	end

	// Cell state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tickets_q <= '0;
			mark_q    <= 1'b0;
		end else if (en) begin
			tickets_q <= tickets_after;
			if (load_hit) begin
				mark_q <= 1'b0;
			end else if (draw_hit) begin
				mark_q <= 1'b1;
			end
		end
	end

	// Token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q <= tok_next;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/core/lottery_ticket_winner_select.sv */
// Pipeline: THREAD_COUNT + 1 register stages, the token register of each thread cell
// and then the result register.
// Throughput: one word per cycle while no result stalls; each word walks the row of thread cells one cell a cycle.
// The whole row and the result register advance together and hold while a result stalls.
// Reset: asynchronous, active low; all ticket counts and has-run marks clear to zero.
module lottery_ticket_winner_select (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ltws_pkg::cmd_word_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output ltws_pkg::res_word_t res
);
	import ltws_pkg::*;

	token_t    tok_c [0:THREAD_COUNT];
	token_t    head;
	logic      en;
	logic      res_valid_q;
	res_word_t res_q;
	token_t    tail;
	logic [CMP_W-1:0] total_w;
	logic [15:0] total_sat;

	// Row advances whenever the result register is free or being drained
	assign en        = !res_valid_q || res_ready;
	assign cmd_ready = en;

	// Fresh token into the first cell
	always_comb begin
		head       = '0;
		head.valid = cmd_valid;
		head.cmd   = cmd;
	end

	assign tok_c[0] = head;

	// Row of thread cells
	for (genvar i = 0; i < THREAD_COUNT; i++) begin : g_cell
		ltws_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.cell_id (ID_W'(i)),
			.tok_in  (tok_c[i]),
			.tok_out (tok_c[i+1])
		);
	end

	assign tail = tok_c[THREAD_COUNT];

	// Saturate the reported total
	assign total_w   = CMP_W'(tail.acc);
	assign total_sat = (total_w > CMP_W'(16'hFFFF)) ? 16'hFFFF : total_w[15:0];

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.winner_index      <= tail.found ? tail.win : 3'd0;
			res_q.winner_found      <= tail.found;
			res_q.winner_ran_before <= tail.found & tail.ran;
			res_q.ticket_total      <= total_sat;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// No winner means zero index and no resume
	a_nowin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.winner_found |-> res.winner_index == 3'd0 && !res.winner_ran_before)
		else $error("result without winner carries index or resume");

	// A winner needs tickets in the table
	a_win_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.winner_found |-> res.ticket_total != 16'd0)
		else $error("winner reported with zero ticket total");

	// Only a draw with a nonzero ticket number can find a winner
	a_win_draw: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid && tail.found |-> tail.cmd.opcode == OP_DRAW
			&& tail.cmd.ticket_number != 16'd0)
		else $error("winner found on a non-draw word");
`endif

endmodule

/* sim/lottery_ticket_winner_select_test.sv */
`timescale 1ns / 100ps

module lottery_ticket_winner_select_test;

	import ltws_pkg::*;

	// Spare opcode: the block must leave its state alone
	localparam logic [1:0] OP_SPARE = 2'd3;

	// One directed row: the word, and a typed result where it is obvious
	typedef struct {
		cmd_word_t word;
		bit        fixed;
		res_word_t want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_word_t res;

	// Typed result travelling alongside the word being offered
	bit        cur_fixed = 1'b0;
	res_word_t cur_fixed_res = '0;

	// Scheduler state as the checker sees it
	ticket_t   ticket_book [THREAD_COUNT];
	bit        ran_mark [THREAD_COUNT];
	// Ticket counts as the stimulus side sees them, used to aim draws
	int        aim_book [THREAD_COUNT];

	res_word_t owed_results [$];
	plan_row_t plan_rows [$];
	int        fault_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	lottery_ticket_winner_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #6 clk = ~clk;

	// Run ends here if the block hangs
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Apply one word to the scheduler state and work out its result
	function automatic res_word_t schedule_outcome(input cmd_word_t w);
		res_word_t r;
		logic [31:0] running;
		logic [31:0] sum;
		bit hit;
		r = '0;
		running = '0;
		sum = '0;
		hit = 1'b0;
		case (w.opcode)
			OP_LOAD: begin
				if (w.thread_index < THREAD_COUNT) begin
					ticket_book[w.thread_index] = ticket_of(w.ticket_count);
					ran_mark[w.thread_index] = 1'b0;
				end
			end
			OP_FINISH: begin
				if (w.thread_index < THREAD_COUNT)
					ticket_book[w.thread_index] = '0;
			end
			OP_DRAW: begin
				// ticket zero never wins
				if (w.ticket_number != 0) begin
					for (int i = 0; i < THREAD_COUNT; i++) begin
						if (!hit) begin
							running += ticket_book[i];
							if (ticket_book[i] != 0 && running >= w.ticket_number) begin
								hit = 1'b1;
								r.winner_index = 3'(i);
								r.winner_found = 1'b1;
								r.winner_ran_before = ran_mark[i];
								ran_mark[i] = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < THREAD_COUNT; i++)
			sum += ticket_book[i];
		r.ticket_total = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fault_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Random stall on the result side
	always @(posedge clk)
		res_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Predict on every accepted command word, compare on every accepted result word
	always @(posedge clk) begin : scoreboard
		res_word_t want;
		res_word_t guess;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				guess = schedule_outcome(cmd);
				owed_results.push_back(cur_fixed ? cur_fixed_res : guess);
			end
			if (res_valid && res_ready) begin
				if (owed_results.size() == 0) begin
					fault_count++;
					$display("%0t: result word with nothing owed, got %p", $time, res);
				end else begin
					want = owed_results.pop_front();
					check_field("winner_index", 16'(want.winner_index),
						16'(res.winner_index));
					check_field("winner_found", 16'(want.winner_found),
						16'(res.winner_found));
					check_field("winner_ran_before", 16'(want.winner_ran_before),
						16'(res.winner_ran_before));
					check_field("ticket_total", want.ticket_total, res.ticket_total);
				end
			end
		end
	end

	// Offer one word after a random gap and hold it until taken
	task automatic push_word(input cmd_word_t w, input bit fixed, input res_word_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		cur_fixed <= fixed;
		cur_fixed_res <= want;
		case (w.opcode)
			OP_LOAD:   aim_book[w.thread_index] = ticket_of(w.ticket_count);
			OP_FINISH: aim_book[w.thread_index] = 0;
			default:   ;
		endcase
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	// Hold off the sender until every owed result has come back
	task automatic await_drain();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (owed_results.size() != 0);
	endtask

	// Random words, draws most often, most of them aimed inside the current total
	task automatic run_phase(input int send_pct, input int stall_pct, input int n);
		cmd_word_t w;
		int total;
		int pick;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < n; k++) begin
			total = 0;
			foreach (aim_book[i])
				total += aim_book[i];
			w.thread_index = 3'($urandom_range(7));
			w.ticket_count = 13'($urandom);
			w.ticket_number = 16'($urandom);
			pick = $urandom_range(99);
			if (pick < 45) begin
				w.opcode = OP_DRAW;
				pick = $urandom_range(99);
				if (total > 0 && pick < 70)
					w.ticket_number = 16'($urandom_range(1, total));
				else if (pick < 78)
					w.ticket_number = '0;
				else if (pick < 90)
					w.ticket_number = 16'(total + 1 + $urandom_range(3));
			end else if (pick < 80) begin
				w.opcode = OP_LOAD;
				pick = $urandom_range(99);
				if (pick < 30)
					w.ticket_count = 13'($urandom_range(1, 16));
				else if (pick < 40)
					w.ticket_count = '0;
				else if (pick < 50)
					w.ticket_count = '1;
				else if (pick < 65)
					w.ticket_count = 13'($urandom_range(1, 512));
			end else if (pick < 92) begin
				w.opcode = OP_FINISH;
			end else begin
				w.opcode = OP_SPARE;
			end
			push_word(w, 1'b0, '0);
		end
		await_drain();
	endtask

	initial begin
		foreach (ticket_book[i]) begin
			ticket_book[i] = '0;
			ran_mark[i] = 1'b0;
			aim_book[i] = 0;
		end

		// Empty table, then edge tickets around a total of 8192
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd1}, 1'b1, '{3'd0, 1'b0, 1'b0, 16'd0}});
		plan_rows.push_back('{'{OP_DRAW, 3'd5, 13'h1FFF, 16'hFFFF}, 1'b1,
			'{3'd0, 1'b0, 1'b0, 16'd0}});
		plan_rows.push_back('{'{OP_LOAD, 3'd0, 13'h1FFF, 16'd0}, 1'b1,
			'{3'd0, 1'b0, 1'b0, 16'd8191}});
		plan_rows.push_back('{'{OP_LOAD, 3'd7, 13'd1, 16'd0}, 1'b1,
			'{3'd0, 1'b0, 1'b0, 16'd8192}});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd0}, 1'b1,
			'{3'd0, 1'b0, 1'b0, 16'd8192}});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd8193}, 1'b1,
			'{3'd0, 1'b0, 1'b0, 16'd8192}});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd8192}, 1'b1,
			'{3'd7, 1'b1, 1'b0, 16'd8192}});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd8192}, 1'b1,
			'{3'd7, 1'b1, 1'b1, 16'd8192}});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd1}, 1'b1,
			'{3'd0, 1'b1, 1'b0, 16'd8192}});
		plan_rows.push_back('{'{OP_FINISH, 3'd7, 13'd0, 16'd0}, 1'b1,
			'{3'd0, 1'b0, 1'b0, 16'd8191}});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd8191}, 1'b1,
			'{3'd0, 1'b1, 1'b1, 16'd8191}});
		// Fill every thread to the top for the largest total
		for (int t = 1; t < THREAD_COUNT; t++)
			plan_rows.push_back('{'{OP_LOAD, 3'(t), 13'h1FFF, 16'd0}, 1'b0, '0});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd65528}, 1'b0, '0});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd65529}, 1'b0, '0});
		// Empty thread in the middle must be skipped
		plan_rows.push_back('{'{OP_LOAD, 3'd3, 13'd0, 16'd0}, 1'b0, '0});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd24573}, 1'b0, '0});
		plan_rows.push_back('{'{OP_DRAW, 3'd0, 13'd0, 16'd24574}, 1'b0, '0});
		plan_rows.push_back('{'{OP_SPARE, 3'd2, 13'h0AAA, 16'h5555}, 1'b0, '0});
		plan_rows.push_back('{'{OP_FINISH, 3'd0, 13'd0, 16'd0}, 1'b0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_rows[i])
			push_word(plan_rows[i].word, plan_rows[i].fixed, plan_rows[i].want);
		await_drain();

		run_phase(0, 0, 130);
		run_phase(54, 0, 130);
		run_phase(0, 54, 130);
		run_phase(10, 10, 130);

		// Let anything stray fall out of the pipeline
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
